>>> sv/atk_pkg.sv
`timescale 1ns / 1ps
package atk_pkg;

    // Widest frame the line buffers can hold
    localparam int MAX_WIDTH = 4096;
    localparam int ADDR_W    = $clog2(MAX_WIDTH);
    localparam int CNT_W     = $clog2(MAX_WIDTH + 1);

    // Field widths of the configuration registers and the pixel stream
    localparam int IMG_W_W    = 13;
    localparam int IMG_H_W    = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CHAN_W     = 8;
    localparam int ERR_W      = 11;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    // Reset values of the frame size
    localparam logic [IMG_W_W-1:0] IMG_WIDTH_RST  = 13'd640;
    localparam logic [IMG_H_W-1:0] IMG_HEIGHT_RST = 16'd480;

    // One line-buffer entry: error owed to the next row and to the row after
    typedef struct packed {
        logic signed [ERR_W-1:0] nre;
        logic signed [ERR_W-1:0] sre;
    } t_line_word;

    // Saturate a 13-bit signed sum to the 11-bit error range
    function automatic logic signed [ERR_W-1:0] sat11(input logic signed [12:0] v);
        logic signed [ERR_W-1:0] r;
        if (v > 13'sd1023) begin
            r = 11'sd1023;
        end else if (v < -13'sd1024) begin
            r = -11'sd1024;
        end else begin
            r = v[ERR_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> sv/atkinson_error_diffusion_dither_core.sv
`timescale 1ns / 1ps
// An accepted pixel is registered in the working stage, then its dot in the output
// register. Throughput: one pixel per cycle unless the output stalls, set by the
// single read and single write port of the line buffer, which is read at the accept
// edge and written as the pixel retires. Reset (synchronous, active low) clears the
// counters, the same-row errors and pipeline, loads 640 x 480, then clears all 4096
// line-buffer entries with tready low; configuration writes are taken throughout.
module atkinson_error_diffusion_dither_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write port
    input  logic                                i_cfg_wr_en,
    input  logic [atk_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [atk_pkg::CFG_DATA_W-1:0]      i_cfg_wr_data,
    // Pixel stream in
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [23:0]                         i_s_axis_tdata,  // red, green, blue
    // Dot stream out
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [7:0]                          o_m_axis_tdata,  // dot, zero fill
    output logic                                o_m_axis_tlast,  // row_end
    output logic                                o_m_axis_tuser   // frame_end
);

    localparam int ADDR_W = atk_pkg::ADDR_W;
    localparam int CNT_W  = atk_pkg::CNT_W;
    localparam int ERR_W  = atk_pkg::ERR_W;
    localparam int CMP_W  = (atk_pkg::IMG_W_W > CNT_W) ? atk_pkg::IMG_W_W : CNT_W;
    localparam int ROW_W  = atk_pkg::IMG_H_W + 1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [atk_pkg::IMG_W_W-1:0] r_img_width;
    logic [atk_pkg::IMG_H_W-1:0] r_img_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_width  <= atk_pkg::IMG_WIDTH_RST;
            r_img_height <= atk_pkg::IMG_HEIGHT_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                atk_pkg::CFG_IMAGE_WIDTH: begin
                    r_img_width <= i_cfg_wr_data[atk_pkg::IMG_W_W-1:0];
                end
                atk_pkg::CFG_IMAGE_HEIGHT: begin
                    r_img_height <= i_cfg_wr_data[atk_pkg::IMG_H_W-1:0];
                end
            endcase
        end
    end

    // Effective sizes: width clamped to 1..MAX_WIDTH, height zero taken as one row
    logic [CMP_W-1:0] w_cfg_ext;
    logic [CNT_W-1:0] w_eff;
    logic [ROW_W-1:0] h_eff;

    always_comb begin
        w_cfg_ext = CMP_W'(r_img_width);
        if (w_cfg_ext == '0) begin
            w_eff = CNT_W'(1);
        end else if (w_cfg_ext > CMP_W'(atk_pkg::MAX_WIDTH)) begin
            w_eff = CNT_W'(atk_pkg::MAX_WIDTH);
        end else begin
            w_eff = w_cfg_ext[CNT_W-1:0];
        end
        h_eff = (r_img_height == '0) ? ROW_W'(1) : ROW_W'(r_img_height);
    end

    // ------------------------------------------------------------------
    // Handshake and clearing pass
    // ------------------------------------------------------------------
    logic                    r_clr_busy;
    logic [ADDR_W-1:0]       r_clr_addr;
    logic                    r_s1_valid;
    logic                    r_out_valid;
    logic                    s1_adv;
    logic                    in_accept;

    assign s1_adv          = r_s1_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_clr_busy && (!r_s1_valid || s1_adv);
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
            if (r_clr_addr == ADDR_W'(atk_pkg::MAX_WIDTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Accept stage: position flags, luma, line-buffer read of column x
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0] r_col;
    logic [atk_pkg::IMG_H_W-1:0] r_row;
    logic              last_col;
    logic              last_row;
    logic              has_second;
    logic              ahead2_in;
    logic [12:0]       luma_sum;

    always_comb begin
        last_col   = (CNT_W'(r_col) + CNT_W'(1)) >= w_eff;
        ahead2_in  = (CNT_W'(r_col) + CNT_W'(2)) < w_eff;
        last_row   = (ROW_W'(r_row) + ROW_W'(1)) >= h_eff;
        has_second = (ROW_W'(r_row) + ROW_W'(2)) < h_eff;
        luma_sum   = 13'd11 * 13'(i_s_axis_tdata[7:0])
                   + 13'd16 * 13'(i_s_axis_tdata[15:8])
                   + 13'd5  * 13'(i_s_axis_tdata[23:16]);
    end

    // Advance the raster position on every pixel transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_accept) begin
            if (last_col) begin
                r_col <= '0;
                r_row <= last_row ? '0 : r_row + atk_pkg::IMG_H_W'(1);
            end else begin
                r_col <= r_col + ADDR_W'(1);
            end
        end
    end

    // Working stage payload
    logic [ADDR_W-1:0] r_s1_x;
    logic [7:0]        r_s1_luma;
    logic              r_s1_last_col;
    logic              r_s1_last_row;
    logic              r_s1_has_second;
    logic              r_s1_ahead2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_x          <= r_col;
            r_s1_luma       <= luma_sum[12:5];
            r_s1_last_col   <= last_col;
            r_s1_last_row   <= last_row;
            r_s1_has_second <= has_second;
            r_s1_ahead2     <= ahead2_in;
        end
    end

    // ------------------------------------------------------------------
    // Line buffer, write held back by one pixel
    // ------------------------------------------------------------------
    // The entry of the previous pixel is still open: the next pixel in the row
    // adds its share for x-1. Hold it in r_dfr_* and write it when the next pixel
    // retires; at a row start it goes out unmodified.
    logic                 r_dfr_valid;
    logic [ADDR_W-1:0]    r_dfr_addr;
    atk_pkg::t_line_word  r_dfr_word;

    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    atk_pkg::t_line_word  wr_data;
    atk_pkg::t_line_word  rd_data;
    atk_pkg::t_line_word  dfr_final;

    assign wr_en   = r_clr_busy || (s1_adv && r_dfr_valid);
    assign wr_addr = r_clr_busy ? r_clr_addr : r_dfr_addr;
    assign wr_data = r_clr_busy ? atk_pkg::t_line_word'('0) : dfr_final;

    atk_line_ram u_line_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (in_accept),
        .i_rd_addr (r_col),
        .o_rd_data (rd_data)
    );

    // Catch a write that lands on the read address at the same edge
    logic                 r_byp_valid;
    atk_pkg::t_line_word  r_byp_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp_valid <= 1'b0;
        end else if (in_accept) begin
            r_byp_valid <= wr_en && (wr_addr == r_col);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_byp_word <= wr_data;
        end
    end

    // ------------------------------------------------------------------
    // Working stage: threshold and error split
    // ------------------------------------------------------------------
    logic signed [ERR_W-1:0] r_ahead_one;
    logic signed [ERR_W-1:0] r_ahead_two;
    logic signed [ERR_W-1:0] r_left;

    atk_pkg::t_line_word     cur;
    logic signed [12:0]      v_sum;
    logic signed [ERR_W-1:0] v;
    logic                    dot;
    logic signed [11:0]      diff;
    logic signed [11:0]      diff_adj;
    logic signed [11:0]      diff_q;
    logic signed [ERR_W-1:0] e;
    logic                    has_next;
    atk_pkg::t_line_word     dfr_next;
    logic signed [ERR_W-1:0] ahead_one_next;

    always_comb begin
        // Newest copy of entry x: the held-back entry, then the caught write
        if (r_dfr_valid && (r_dfr_addr == r_s1_x)) begin
            cur = r_dfr_word;
        end else if (r_byp_valid) begin
            cur = r_byp_word;
        end else begin
            cur = rd_data;
        end

        has_next = !r_s1_last_row;

        v_sum = $signed({5'b0, r_s1_luma})
              + $signed({{2{cur.nre[ERR_W-1]}}, cur.nre})
              + $signed({{2{r_ahead_one[ERR_W-1]}}, r_ahead_one});
        v     = atk_pkg::sat11(v_sum);
        dot   = v >= 11'sd127;
        diff  = dot ? ($signed({v[ERR_W-1], v}) - 12'sd255) : $signed({v[ERR_W-1], v});

        // Divide by eight, truncating toward zero
        diff_adj = diff + (diff[11] ? 12'sd7 : 12'sd0);
        diff_q   = diff_adj >>> 3;
        e        = diff_q[ERR_W-1:0];

        // Close the held-back entry with this pixel's share for x-1
        dfr_final = r_dfr_word;
        if (r_s1_x != '0) begin
            dfr_final.nre = has_next
                ? atk_pkg::sat11($signed({{2{r_dfr_word.nre[ERR_W-1]}}, r_dfr_word.nre})
                                 + $signed({{2{e[ERR_W-1]}}, e}))
                : '0;
        end

        // Open entry x: next-row share at x plus the left pixel's x+1 share
        dfr_next.nre = has_next
            ? atk_pkg::sat11($signed({{2{cur.sre[ERR_W-1]}}, cur.sre})
                             + $signed({{2{r_left[ERR_W-1]}}, r_left})
                             + $signed({{2{e[ERR_W-1]}}, e}))
            : '0;
        dfr_next.sre = r_s1_has_second ? e : '0;

        ahead_one_next = atk_pkg::sat11($signed({{2{r_ahead_two[ERR_W-1]}}, r_ahead_two})
                                        + $signed({{2{e[ERR_W-1]}}, e}));
    end

    // Retire the pixel: same-row errors and the held-back entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ahead_one <= '0;
            r_ahead_two <= '0;
            r_left      <= '0;
            r_dfr_valid <= 1'b0;
        end else if (s1_adv) begin
            r_ahead_one <= r_s1_last_col ? '0 : ahead_one_next;
            r_ahead_two <= r_s1_ahead2 ? e : '0;
            r_left      <= r_s1_last_col ? '0 : e;
            r_dfr_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_dfr_addr <= r_s1_x;
            r_dfr_word <= dfr_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic r_out_dot;
    logic r_out_row_end;
    logic r_out_frame_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_dot       <= dot;
            r_out_row_end   <= r_s1_last_col;
            r_out_frame_end <= r_s1_last_col && r_s1_last_row;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'b0, r_out_dot};
    assign o_m_axis_tlast  = r_out_row_end;
    assign o_m_axis_tuser  = r_out_frame_end;

`ifndef SYNTH
    // No pixel enters while the line buffer is being cleared
    a_no_accept_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !o_s_axis_tready)
        else $error("pixel accepted during clearing pass");

    // Inside a row the held-back entry is always the column just before
    a_dfr_is_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_dfr_valid && (r_s1_x != '0))
            |-> (r_dfr_addr == (r_s1_x - ADDR_W'(1))))
        else $error("held-back entry not at x-1");

    // A frame ends only on the last pixel of a row
    a_frame_end_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> o_m_axis_tlast)
        else $error("frame end without row end");

    // An accepted pixel occupies the working stage at the next edge
    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_s1_valid)
        else $error("accepted pixel lost");
`endif

endmodule

>>> sv/atk_line_ram.sv
`timescale 1ns / 1ps
module atk_line_ram (
    input  logic                            i_clk,
    input  logic                            i_wr_en,
    input  logic [atk_pkg::ADDR_W-1:0]      i_wr_addr,
    input  atk_pkg::t_line_word             i_wr_data,
    input  logic                            i_rd_en,
    input  logic [atk_pkg::ADDR_W-1:0]      i_rd_addr,
    output atk_pkg::t_line_word             o_rd_data
);

    atk_pkg::t_line_word r_mem [atk_pkg::MAX_WIDTH];
    atk_pkg::t_line_word r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read data is registered; a same-cycle write is not seen here
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
